@@ hdl/sat_pkg.sv @@
// shared types and constants for the sorted annotation table
// no dependencies; imported by every module of the block
`default_nettype none

package sat_pkg;

    localparam int TABLE_DEPTH_DEF = 64;
    localparam int KEY_W           = 48;
    localparam int ATTR_W          = 32;
    localparam int ENTRY_W         = KEY_W + ATTR_W;
    localparam int COUNT_OUT_W     = 7;
    localparam int INDEX_IN_W      = 6;

    // offset number is kept biased so that the key sorts as unsigned
    localparam logic [7:0] NUM_BIAS = 8'h80;

    typedef enum logic [1:0] {
        ACT_INSERT = 2'd0,
        ACT_DELETE = 2'd1,
        ACT_READ   = 2'd2
    } action_t;

    typedef enum logic [2:0] {
        ST_OK       = 3'd0,
        ST_DELETED  = 3'd1,
        ST_NO_MATCH = 3'd2,
        ST_FULL     = 3'd3,
        ST_RANGE    = 3'd4
    } status_t;

    typedef enum logic [1:0] {
        RD_TOP   = 2'd0,
        RD_DOWN  = 2'd1,
        RD_UP    = 2'd2,
        RD_INDEX = 2'd3
    } rd_sel_t;

    typedef enum logic [1:0] {
        WR_NEW_ZERO   = 2'd0,
        WR_NEW_ABOVE  = 2'd1,
        WR_SHIFT_UP   = 2'd2,
        WR_SHIFT_DOWN = 2'd3
    } wr_sel_t;

    typedef struct packed {
        logic    load_item;
        logic    rd_en;
        rd_sel_t rd_sel;
        logic    wr_en;
        wr_sel_t wr_sel;
        logic    status_we;
        status_t status_code;
        logic    count_inc;
        logic    count_dec;
        logic    emit;
    } sat_cmd_t;

    typedef struct packed {
        action_t action;
        logic    full;
        logic    empty;
        logic    index_ok;
        logic    key_ge;
        logic    match;
        logic    idx_zero;
        logic    idx_last;
        logic    out_free;
    } sat_stat_t;

endpackage

`default_nettype wire

@@ hdl/sat_ram.sv @@
// generic single-write, single-read ram with registered read data
// depends on sat_pkg for default sizes
`default_nettype none

module sat_ram
    import sat_pkg::*;
#(
    parameter int WIDTH = ENTRY_W,
    parameter int DEPTH = TABLE_DEPTH_DEF,
    localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
)
(
    input  wire logic              clk,
    input  wire logic              wr_en,
    input  wire logic [ADDR_W-1:0] wr_addr,
    input  wire logic [WIDTH-1:0]  wr_data,
    input  wire logic              rd_en,
    input  wire logic [ADDR_W-1:0] rd_addr,
    output logic      [WIDTH-1:0]  rd_data
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem_reg[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem_reg[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

`default_nettype wire

@@ hdl/sat_datapath.sv @@
// datapath of the sorted annotation table: item registers, entry ram,
// scan index, count, compares and the output register; uses sat_pkg, sat_ram
`default_nettype none

module sat_datapath
    import sat_pkg::*;
#(
    parameter int TABLE_DEPTH = TABLE_DEPTH_DEF
)
(
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire sat_cmd_t               cmd,
    output sat_stat_t                   stat,
    input  wire logic [1:0]             action,
    input  wire logic [31:0]            event_time,
    input  wire logic [7:0]             channel,
    input  wire logic signed [7:0]      offset_num,
    input  wire logic [7:0]             ann_type,
    input  wire logic signed [7:0]      sub_type,
    input  wire logic [15:0]            aux_tag,
    input  wire logic [INDEX_IN_W-1:0]  read_index,
    input  wire logic                   out_stall,
    output logic                        out_valid,
    output logic [2:0]                  status,
    output logic [COUNT_OUT_W-1:0]      entry_count,
    output logic [31:0]                 out_time,
    output logic [7:0]                  out_channel,
    output logic signed [7:0]           out_offset_num,
    output logic [7:0]                  out_type,
    output logic signed [7:0]           out_sub_type,
    output logic [15:0]                 out_aux_tag
);

    localparam int IDX_W = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
    localparam int CNT_W = $clog2(TABLE_DEPTH + 1);
    localparam int CMP_W = (CNT_W > INDEX_IN_W) ? CNT_W : INDEX_IN_W;

    action_t               act_reg;
    logic [KEY_W-1:0]      key_reg;
    logic [ATTR_W-1:0]     attr_reg;
    logic [INDEX_IN_W-1:0] rindex_reg;
    logic [IDX_W-1:0]      idx_reg;
    logic [IDX_W-1:0]      idx_next;
    logic [CNT_W-1:0]      count_reg;
    logic [CNT_W-1:0]      count_next;
    status_t               status_reg;

    logic                  out_valid_reg;
    logic [2:0]            status_out_reg;
    logic [COUNT_OUT_W-1:0] count_out_reg;
    logic [ENTRY_W-1:0]    entry_out_reg;

    logic                  rd_en;
    logic [IDX_W-1:0]      rd_addr;
    logic [ENTRY_W-1:0]    rd_data;
    logic                  wr_en;
    logic [IDX_W-1:0]      wr_addr;
    logic [ENTRY_W-1:0]    wr_data;
    logic [ENTRY_W-1:0]    new_entry;
    logic [KEY_W-1:0]      rd_key;
    logic                  out_free;

    assign new_entry = {key_reg, attr_reg};
    assign rd_key    = rd_data[ENTRY_W-1 -: KEY_W];
    assign out_free  = !out_valid_reg || !out_stall;

    // item capture, key built with the biased offset number
    always_ff @(posedge clk)
    begin
        if (cmd.load_item)
        begin
            act_reg    <= action_t'(action);
            key_reg    <= {event_time, channel, unsigned'(offset_num) ^ NUM_BIAS};
            attr_reg   <= {ann_type, unsigned'(sub_type), aux_tag};
            rindex_reg <= read_index;
        end
        if (cmd.status_we)
        begin
            status_reg <= cmd.status_code;
        end
        idx_reg <= idx_next;
    end

    // ram read port
    always_comb
    begin
        rd_en = cmd.rd_en;
        case (cmd.rd_sel)
            RD_TOP:   rd_addr = IDX_W'(count_reg - CNT_W'(1));
            RD_DOWN:  rd_addr = idx_reg - IDX_W'(1);
            RD_UP:    rd_addr = idx_reg + IDX_W'(1);
            RD_INDEX: rd_addr = IDX_W'(rindex_reg);
            default:  rd_addr = idx_reg;
        endcase
        idx_next = cmd.rd_en ? rd_addr : idx_reg;
    end

    // ram write port
    always_comb
    begin
        wr_en = cmd.wr_en;
        case (cmd.wr_sel)
            WR_NEW_ZERO:
            begin
                wr_addr = '0;
                wr_data = new_entry;
            end
            WR_NEW_ABOVE:
            begin
                wr_addr = idx_reg + IDX_W'(1);
                wr_data = new_entry;
            end
            WR_SHIFT_UP:
            begin
                wr_addr = idx_reg + IDX_W'(1);
                wr_data = rd_data;
            end
            WR_SHIFT_DOWN:
            begin
                wr_addr = idx_reg - IDX_W'(1);
                wr_data = rd_data;
            end
            default:
            begin
                wr_addr = idx_reg;
                wr_data = new_entry;
            end
        endcase
    end

    sat_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (TABLE_DEPTH)
    ) u_entry_ram (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    always_comb
    begin
        count_next = count_reg;
        if (cmd.count_inc)
        begin
            count_next = count_reg + CNT_W'(1);
        end
        else if (cmd.count_dec)
        begin
            count_next = count_reg - CNT_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            count_reg <= count_next;
            if (cmd.emit)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // result beat; entry fields only for a successful read
    always_ff @(posedge clk)
    begin
        if (cmd.emit)
        begin
            status_out_reg <= status_reg;
            count_out_reg  <= COUNT_OUT_W'(count_reg);
            if (act_reg == ACT_READ && status_reg == ST_OK)
            begin
                entry_out_reg <= rd_data;
            end
            else
            begin
                entry_out_reg <= {KEY_W'(0), ATTR_W'(0)} ^ {{(KEY_W-8){1'b0}}, NUM_BIAS,
                                 ATTR_W'(0)};
            end
        end
    end

    assign out_valid      = out_valid_reg;
    assign status         = status_out_reg;
    assign entry_count    = count_out_reg;
    assign out_time       = entry_out_reg[ENTRY_W-1 -: 32];
    assign out_channel    = entry_out_reg[ATTR_W+15 -: 8];
    assign out_offset_num = signed'(entry_out_reg[ATTR_W+7 -: 8] ^ NUM_BIAS);
    assign out_type       = entry_out_reg[31:24];
    assign out_sub_type   = signed'(entry_out_reg[23:16]);
    assign out_aux_tag    = entry_out_reg[15:0];

    always_comb
    begin
        stat.action   = act_reg;
        stat.full     = (count_reg == CNT_W'(TABLE_DEPTH));
        stat.empty    = (count_reg == '0);
        stat.index_ok = (CMP_W'(rindex_reg) < CMP_W'(count_reg));
        stat.key_ge   = (rd_key >= key_reg);
        stat.match    = (rd_data == new_entry);
        stat.idx_zero = (idx_reg == '0);
        stat.idx_last = ((CNT_W'(idx_reg) + CNT_W'(1)) == count_reg);
        stat.out_free = out_free;
    end

endmodule

`default_nettype wire

@@ hdl/sat_ctrl.sv @@
// controller of the sorted annotation table: one-hot sequencer that walks
// the entry ram for insert and delete and reads one entry for read; uses sat_pkg
`default_nettype none

module sat_ctrl
    import sat_pkg::*;
(
    input  wire logic      clk,
    input  wire logic      rst_n,
    input  wire logic      in_valid,
    output logic           in_stall,
    output sat_cmd_t       cmd,
    input  wire sat_stat_t stat
);

    typedef enum logic [6:0] {
        S_IDLE     = 7'b0000001,
        S_DISPATCH = 7'b0000010,
        S_INS_SCAN = 7'b0000100,
        S_INS_PUT  = 7'b0001000,
        S_DEL_SCAN = 7'b0010000,
        S_DEL_MOVE = 7'b0100000,
        S_RESP     = 7'b1000000
    } state_t;

    state_t state_reg;
    state_t state_next;

    assign in_stall = (state_reg != S_IDLE);

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.load_item = 1'b1;
                    state_next    = S_DISPATCH;
                end
            end
            S_DISPATCH:
            begin
                state_next    = S_RESP;
                cmd.status_we = 1'b1;
                case (stat.action)
                    ACT_INSERT:
                    begin
                        if (stat.full)
                        begin
                            cmd.status_code = ST_FULL;
                        end
                        else if (stat.empty)
                        begin
                            cmd.wr_en       = 1'b1;
                            cmd.wr_sel      = WR_NEW_ZERO;
                            cmd.count_inc   = 1'b1;
                            cmd.status_code = ST_OK;
                        end
                        else
                        begin
                            cmd.status_we = 1'b0;
                            cmd.rd_en     = 1'b1;
                            cmd.rd_sel    = RD_TOP;
                            state_next    = S_INS_SCAN;
                        end
                    end
                    ACT_DELETE:
                    begin
                        if (stat.empty)
                        begin
                            cmd.status_code = ST_NO_MATCH;
                        end
                        else
                        begin
                            cmd.status_we = 1'b0;
                            cmd.rd_en     = 1'b1;
                            cmd.rd_sel    = RD_TOP;
                            state_next    = S_DEL_SCAN;
                        end
                    end
                    ACT_READ:
                    begin
                        if (stat.index_ok)
                        begin
                            cmd.rd_en       = 1'b1;
                            cmd.rd_sel      = RD_INDEX;
                            cmd.status_code = ST_OK;
                        end
                        else
                        begin
                            cmd.status_code = ST_RANGE;
                        end
                    end
                    default:
                    begin
                        cmd.status_code = ST_NO_MATCH;
                    end
                endcase
            end
            S_INS_SCAN:
            begin
                if (stat.key_ge)
                begin
                    cmd.wr_en  = 1'b1;
                    cmd.wr_sel = WR_SHIFT_UP;
                    if (stat.idx_zero)
                    begin
                        state_next = S_INS_PUT;
                    end
                    else
                    begin
                        cmd.rd_en  = 1'b1;
                        cmd.rd_sel = RD_DOWN;
                    end
                end
                else
                begin
                    cmd.wr_en       = 1'b1;
                    cmd.wr_sel      = WR_NEW_ABOVE;
                    cmd.count_inc   = 1'b1;
                    cmd.status_we   = 1'b1;
                    cmd.status_code = ST_OK;
                    state_next      = S_RESP;
                end
            end
            S_INS_PUT:
            begin
                cmd.wr_en       = 1'b1;
                cmd.wr_sel      = WR_NEW_ZERO;
                cmd.count_inc   = 1'b1;
                cmd.status_we   = 1'b1;
                cmd.status_code = ST_OK;
                state_next      = S_RESP;
            end
            S_DEL_SCAN:
            begin
                if (stat.match)
                begin
                    if (stat.idx_last)
                    begin
                        cmd.count_dec   = 1'b1;
                        cmd.status_we   = 1'b1;
                        cmd.status_code = ST_DELETED;
                        state_next      = S_RESP;
                    end
                    else
                    begin
                        cmd.rd_en  = 1'b1;
                        cmd.rd_sel = RD_UP;
                        state_next = S_DEL_MOVE;
                    end
                end
                else if (stat.idx_zero)
                begin
                    cmd.status_we   = 1'b1;
                    cmd.status_code = ST_NO_MATCH;
                    state_next      = S_RESP;
                end
                else
                begin
                    cmd.rd_en  = 1'b1;
                    cmd.rd_sel = RD_DOWN;
                end
            end
            S_DEL_MOVE:
            begin
                cmd.wr_en  = 1'b1;
                cmd.wr_sel = WR_SHIFT_DOWN;
                if (stat.idx_last)
                begin
                    cmd.count_dec   = 1'b1;
                    cmd.status_we   = 1'b1;
                    cmd.status_code = ST_DELETED;
                    state_next      = S_RESP;
                end
                else
                begin
                    cmd.rd_en  = 1'b1;
                    cmd.rd_sel = RD_UP;
                end
            end
            S_RESP:
            begin
                if (stat.out_free)
                begin
                    cmd.emit   = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule

`default_nettype wire

@@ hdl/sorted_annotation_table_core.sv @@
// top level of the sorted annotation table
// depends on sat_pkg, sat_ctrl, sat_datapath (and through it sat_ram)
`default_nettype none

// The table keeps up to TABLE_DEPTH annotations in ascending order of a
// 48-bit key (event_time, channel, offset_num biased by 128), one entry per
// word of a single-port-write, single-port-read ram with registered read.
// Each input beat is one operation: insert (placed before any equal key;
// a full table answers status 3), delete of the last exact match on key,
// type, subtype and aux tag (status 1, or 2 when nothing matches), or read
// of the entry at read_index (status 0, or 4 past the count). Every input
// beat gives exactly one result beat carrying the count after the
// operation; the entry fields are zero except on a successful read.
// Operations run one at a time. A read, a rejected insert, an insert into an
// empty table, a delete on an empty table or an unused action code goes from
// the dispatch state to the result state. Any other insert walks the
// ram from the top down and moves each entry that sorts at or above the new
// key up, one entry per cycle. A delete scans down one entry per cycle until
// it finds the match and then moves the entries above it down one per cycle.
// The one entry per cycle limit comes from the single read port and single
// write port of the entry ram. The input is stalled while an operation runs;
// a finished result sits in the output register while the next beat is
// taken, and the next result waits for it. No clearing pass is needed after
// reset: only entries below the count are ever read.
module sorted_annotation_table_core
    import sat_pkg::*;
#(
    parameter int TABLE_DEPTH = TABLE_DEPTH_DEF
)
(
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    // input channel
    input  wire logic                   in_valid,
    output logic                        in_stall,
    input  wire logic [1:0]             action,
    input  wire logic [31:0]            event_time,
    input  wire logic [7:0]             channel,
    input  wire logic signed [7:0]      offset_num,
    input  wire logic [7:0]             ann_type,
    input  wire logic signed [7:0]      sub_type,
    input  wire logic [15:0]            aux_tag,
    input  wire logic [INDEX_IN_W-1:0]  read_index,
    // result channel
    output logic                        out_valid,
    input  wire logic                   out_stall,
    output logic [2:0]                  status,
    output logic [COUNT_OUT_W-1:0]      entry_count,
    output logic [31:0]                 out_time,
    output logic [7:0]                  out_channel,
    output logic signed [7:0]           out_offset_num,
    output logic [7:0]                  out_type,
    output logic signed [7:0]           out_sub_type,
    output logic [15:0]                 out_aux_tag
);

    // command and status between sequencer and datapath
    sat_cmd_t  cmd;
    sat_stat_t stat;

    // sequencer: accepts a beat in idle, then steps the ram walk
    sat_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .cmd      (cmd),
        .stat     (stat)
    );

    // datapath: item registers, entry ram, compares, count, output register
    sat_datapath #(
        .TABLE_DEPTH (TABLE_DEPTH)
    ) u_datapath (
        .clk            (clk),
        .rst_n          (rst_n),
        .cmd            (cmd),
        .stat           (stat),
        .action         (action),
        .event_time     (event_time),
        .channel        (channel),
        .offset_num     (offset_num),
        .ann_type       (ann_type),
        .sub_type       (sub_type),
        .aux_tag        (aux_tag),
        .read_index     (read_index),
        .out_stall      (out_stall),
        .out_valid      (out_valid),
        .status         (status),
        .entry_count    (entry_count),
        .out_time       (out_time),
        .out_channel    (out_channel),
        .out_offset_num (out_offset_num),
        .out_type       (out_type),
        .out_sub_type   (out_sub_type),
        .out_aux_tag    (out_aux_tag)
    );

endmodule

`default_nettype wire

@@ hdl/sat_checker.sv @@
// port-level checks for the sorted annotation table and their bind
// depends on sat_pkg and sorted_annotation_table_core
`default_nettype none

module sat_checker
    import sat_pkg::*;
#(
    parameter int TABLE_DEPTH = TABLE_DEPTH_DEF
)
(
    input wire logic                   clk,
    input wire logic                   rst_n,
    input wire logic                   in_valid,
    input wire logic                   in_stall,
    input wire logic                   out_valid,
    input wire logic                   out_stall,
    input wire logic [2:0]             status,
    input wire logic [COUNT_OUT_W-1:0] entry_count,
    input wire logic [31:0]            out_time,
    input wire logic [7:0]             out_channel,
    input wire logic signed [7:0]      out_offset_num,
    input wire logic [7:0]             out_type,
    input wire logic signed [7:0]      out_sub_type,
    input wire logic [15:0]            out_aux_tag
);

    // stalled result beat holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(status) && $stable(entry_count)
            && $stable(out_time))
        else $error("result beat changed while stalled");

    // one operation at a time: a taken beat stalls the input next cycle
    a_busy_after_take: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall |=> in_stall)
        else $error("input not stalled after taking a beat");

    // full status only with a full table
    a_full_count: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && status == ST_FULL |-> entry_count == COUNT_OUT_W'(TABLE_DEPTH))
        else $error("table full reported with room left");

    // entry fields are zero unless the status is ok
    a_zero_fields: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && status != ST_OK |-> out_time == '0 && out_channel == '0
            && out_offset_num == '0 && out_type == '0 && out_sub_type == '0
            && out_aux_tag == '0)
        else $error("entry fields set on a result that is not a read");

    // a result beat only carries a defined status code
    a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> status <= ST_RANGE)
        else $error("undefined status code on a result beat");

endmodule

bind sorted_annotation_table_core sat_checker #(
    .TABLE_DEPTH (TABLE_DEPTH)
) u_sat_checker (.*);

`default_nettype wire

@@ tb/sat_table_checker.sv @@
// checker for the sorted annotation table: watches both channels, predicts every reply
// from its own copy of the sorted table and compares field by field
// depends on sat_pkg
`timescale 1ns / 1ps

module sat_table_checker
    import sat_pkg::*;
#(
    parameter int DEPTH = TABLE_DEPTH_DEF
)
(
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire logic                   in_valid,
    input  wire logic                   in_stall,
    input  wire logic [1:0]             action,
    input  wire logic [31:0]            event_time,
    input  wire logic [7:0]             channel,
    input  wire logic signed [7:0]      offset_num,
    input  wire logic [7:0]             ann_type,
    input  wire logic signed [7:0]      sub_type,
    input  wire logic [15:0]            aux_tag,
    input  wire logic [INDEX_IN_W-1:0]  read_index,
    input  wire logic                   out_valid,
    input  wire logic                   out_stall,
    input  wire logic [2:0]             status,
    input  wire logic [COUNT_OUT_W-1:0] entry_count,
    input  wire logic [31:0]            out_time,
    input  wire logic [7:0]             out_channel,
    input  wire logic signed [7:0]      out_offset_num,
    input  wire logic [7:0]             out_type,
    input  wire logic signed [7:0]      out_sub_type,
    input  wire logic [15:0]            out_aux_tag,
    output int                          fail_count,
    output int                          pending,
    output int                          replies_checked,
    output int                          peak_fill,
    output int                          full_rejects,
    output int                          unmatched_deletes
);

    typedef struct packed {
        logic [1:0]            op;
        logic [31:0]           tm;
        logic [7:0]            ch;
        logic [7:0]            num;
        logic [7:0]            ty;
        logic [7:0]            st;
        logic [15:0]           aux;
        logic [INDEX_IN_W-1:0] idx;
    } table_op_t;

    typedef struct packed {
        logic [2:0]             status;
        logic [COUNT_OUT_W-1:0] count;
        logic [31:0]            tm;
        logic [7:0]             ch;
        logic [7:0]             num;
        logic [7:0]             ty;
        logic [7:0]             st;
        logic [15:0]            aux;
    } table_reply_t;

    logic [KEY_W-1:0]  sorted_keys  [DEPTH];
    logic [ATTR_W-1:0] sorted_attrs [DEPTH];
    int                fill;
    table_reply_t      reply_q [$];
    table_reply_t      want;
    table_op_t         op_in;

    // one table operation on the local copy, returns the reply it must produce
    function automatic table_reply_t apply_table_op(table_op_t o);
        table_reply_t      r;
        logic [KEY_W-1:0]  key;
        logic [ATTR_W-1:0] attrs;
        int                pos;
        r = '0;
        r.status = ST_NO_MATCH;
        key = {o.tm, o.ch, o.num ^ NUM_BIAS};
        attrs = {o.ty, o.st, o.aux};
        case (o.op)
            ACT_INSERT:
            begin
                if (fill >= DEPTH)
                begin
                    r.status = ST_FULL;
                end
                else
                begin
                    // lands before every equal key
                    pos = 0;
                    while (pos < fill && sorted_keys[pos] < key)
                        pos++;
                    for (int i = fill; i > pos; i--)
                    begin
                        sorted_keys[i] = sorted_keys[i-1];
                        sorted_attrs[i] = sorted_attrs[i-1];
                    end
                    sorted_keys[pos] = key;
                    sorted_attrs[pos] = attrs;
                    fill++;
                    r.status = ST_OK;
                end
            end
            ACT_DELETE:
            begin
                // last exact match in sorted order
                pos = -1;
                for (int i = fill - 1; i >= 0; i--)
                begin
                    if (sorted_keys[i] == key && sorted_attrs[i] == attrs)
                    begin
                        pos = i;
                        break;
                    end
                end
                if (pos >= 0)
                begin
                    for (int i = pos; i + 1 < fill; i++)
                    begin
                        sorted_keys[i] = sorted_keys[i+1];
                        sorted_attrs[i] = sorted_attrs[i+1];
                    end
                    fill--;
                    r.status = ST_DELETED;
                end
            end
            ACT_READ:
            begin
                if (int'(o.idx) < fill)
                begin
                    r.status = ST_OK;
                    r.tm = sorted_keys[o.idx][47:16];
                    r.ch = sorted_keys[o.idx][15:8];
                    r.num = sorted_keys[o.idx][7:0] ^ NUM_BIAS;
                    r.ty = sorted_attrs[o.idx][31:24];
                    r.st = sorted_attrs[o.idx][23:16];
                    r.aux = sorted_attrs[o.idx][15:0];
                end
                else
                begin
                    r.status = ST_RANGE;
                end
            end
            default:
            begin
                r.status = ST_NO_MATCH;
            end
        endcase
        r.count = COUNT_OUT_W'(fill);
        return r;
    endfunction

    task automatic compare_field(string name, logic [31:0] want_v, logic [31:0] got_v);
        if (want_v !== got_v)
        begin
            fail_count++;
            $error("%s mismatch: expected 0x%0h, got 0x%0h", name, want_v, got_v);
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fill = 0;
            reply_q.delete();
            pending = 0;
            fail_count = 0;
            replies_checked = 0;
            peak_fill = 0;
            full_rejects = 0;
            unmatched_deletes = 0;
        end
        else
        begin
            // a reply always belongs to an earlier beat, so pop before push
            if (out_valid && !out_stall)
            begin
                replies_checked++;
                if (reply_q.size() == 0)
                begin
                    fail_count++;
                    $error("reply beat with nothing outstanding, status 0x%0h", status);
                end
                else
                begin
                    want = reply_q.pop_front();
                    compare_field("status", want.status, status);
                    compare_field("entry_count", want.count, entry_count);
                    compare_field("out_time", want.tm, out_time);
                    compare_field("out_channel", want.ch, out_channel);
                    compare_field("out_offset_num", want.num, $unsigned(out_offset_num));
                    compare_field("out_type", want.ty, out_type);
                    compare_field("out_sub_type", want.st, $unsigned(out_sub_type));
                    compare_field("out_aux_tag", want.aux, out_aux_tag);
                end
            end
            if (in_valid && !in_stall)
            begin
                op_in.op = action;
                op_in.tm = event_time;
                op_in.ch = channel;
                op_in.num = offset_num;
                op_in.ty = ann_type;
                op_in.st = sub_type;
                op_in.aux = aux_tag;
                op_in.idx = read_index;
                want = apply_table_op(op_in);
                if (want.status == ST_FULL)
                    full_rejects++;
                if (op_in.op == ACT_DELETE && want.status == ST_NO_MATCH)
                    unmatched_deletes++;
                if (fill > peak_fill)
                    peak_fill = fill;
                reply_q.push_back(want);
            end
            pending = reply_q.size();
        end
    end

endmodule

@@ tb/tb_sorted_annotation_table_core.sv @@
// testbench top for sorted_annotation_table_core: clock, reset, stimulus and verdict
// depends on sat_pkg, the block's rtl and sat_table_checker
`timescale 1ns / 1ps

module tb_sorted_annotation_table_core
    import sat_pkg::*;
;

    // action code the block has no operation for, answered as no match
    localparam logic [1:0] ACT_UNUSED = 2'd3;
    // receiver hold-off long enough to back the block up into its input
    localparam int HOLD_CYCLES = 200;
    // longest single operation is a delete scan plus compaction
    localparam int DRAIN_CYCLES = 2 * TABLE_DEPTH_DEF + 16;

    // one annotation as the stimulus side sees it
    typedef struct packed {
        logic [31:0] tm;
        logic [7:0]  ch;
        logic [7:0]  num;
        logic [7:0]  ty;
        logic [7:0]  st;
        logic [15:0] aux;
    } ann_entry_t;

    logic                   clk = 1'b0;
    logic                   rst_n;
    logic                   in_valid;
    logic                   in_stall;
    logic [1:0]             action;
    logic [31:0]            event_time;
    logic [7:0]             channel;
    logic signed [7:0]      offset_num;
    logic [7:0]             ann_type;
    logic signed [7:0]      sub_type;
    logic [15:0]            aux_tag;
    logic [INDEX_IN_W-1:0]  read_index;
    logic                   out_valid;
    logic                   out_stall;
    logic [2:0]             status;
    logic [COUNT_OUT_W-1:0] entry_count;
    logic [31:0]            out_time;
    logic [7:0]             out_channel;
    logic signed [7:0]      out_offset_num;
    logic [7:0]             out_type;
    logic signed [7:0]      out_sub_type;
    logic [15:0]            out_aux_tag;

    int fail_count;
    int pending;
    int replies_checked;
    int peak_fill;
    int full_rejects;
    int unmatched_deletes;

    // idle rates of the two sides, changed per phase
    int send_idle_pct;
    int recv_idle_pct;
    // bumped by the stimulus to ask the receiver for one long hold-off
    int hold_trig = 0;
    // beats sent per action code
    int ops_sent [4];
    // mirror of what the table holds, used to aim deletes, reads and equal-key inserts and to steer the fill level
    ann_entry_t live_entries [$];
    // random walk direction of the fill level
    bit filling;

    sorted_annotation_table_core uut (.*);

    sat_table_checker u_table_checker (.*);

    always #1 clk = ~clk;

    // result side: random stalls, plus the long hold-off on request
    initial
    begin
        int hold_left;
        int hold_seen;
        hold_left = 0;
        hold_seen = 0;
        out_stall = 1'b0;
        forever
        begin
            @(negedge clk);
            if (hold_seen != hold_trig)
            begin
                hold_seen = hold_trig;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                out_stall <= 1'b1;
            end
            else
            begin
                out_stall <= ($urandom_range(99) < recv_idle_pct);
            end
        end
    end

    // annotation with values bunched near the extremes and on a few shared times,
    // so that equal keys and neighbors in the sort order turn up often
    function automatic ann_entry_t random_entry();
        ann_entry_t e;
        case ($urandom_range(9))
            0, 1, 2, 3: e.tm = 32'($urandom_range(3));
            4:          e.tm = 32'hFFFF_FFFF - 32'($urandom_range(1));
            default:    e.tm = $urandom();
        endcase
        e.ch = ($urandom_range(2) == 0) ? 8'($urandom_range(1) * 255) : 8'($urandom_range(255));
        case ($urandom_range(5))
            0:       e.num = 8'h80;
            1:       e.num = 8'h7F;
            2:       e.num = 8'h00;
            default: e.num = 8'($urandom_range(255));
        endcase
        e.ty = 8'($urandom_range(255));
        e.st = 8'($urandom_range(255));
        e.aux = ($urandom_range(2) == 0) ? 16'h0000 : 16'($urandom_range(65535));
        return e;
    endfunction

    // one input beat: optional idle cycles, then hold the payload until taken
    task automatic issue_op(logic [1:0] op, ann_entry_t e, logic [INDEX_IN_W-1:0] idx);
        while ($urandom_range(99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        action <= op;
        event_time <= e.tm;
        channel <= e.ch;
        offset_num <= e.num;
        ann_type <= e.ty;
        sub_type <= e.st;
        aux_tag <= e.aux;
        read_index <= idx;
        in_valid <= 1'b1;
        do
            @(posedge clk);
        while (in_stall);
        @(negedge clk);
        ops_sent[op]++;
    endtask

    // insert, keeping the mirror in step (a full table takes nothing)
    task automatic do_insert(ann_entry_t e);
        issue_op(ACT_INSERT, e, INDEX_IN_W'($urandom_range(63)));
        if (live_entries.size() < TABLE_DEPTH_DEF)
            live_entries.push_back(e);
    endtask

    // delete, dropping one identical entry from the mirror if there is one
    task automatic do_delete(ann_entry_t e);
        issue_op(ACT_DELETE, e, INDEX_IN_W'($urandom_range(63)));
        foreach (live_entries[i])
        begin
            if (live_entries[i] == e)
            begin
                live_entries.delete(i);
                break;
            end
        end
    endtask

    // random operations; the fill level wanders between empty and full so that
    // full-table inserts and empty-table deletes both come up
    task automatic random_ops(int n);
        int         sz;
        int         pick;
        ann_entry_t e;
        ann_entry_t twin;
        for (int k = 0; k < n; k++)
        begin
            sz = live_entries.size();
            if (filling && sz >= TABLE_DEPTH_DEF && $urandom_range(5) == 0)
                filling = 1'b0;
            else if (!filling && sz == 0 && $urandom_range(3) == 0)
                filling = 1'b1;
            pick = $urandom_range(99);
            if (pick < (filling ? 55 : 15))
            begin
                e = random_entry();
                // reuse a stored key now and then, so equal keys pile up
                if (sz > 0 && $urandom_range(3) == 0)
                begin
                    twin = live_entries[$urandom_range(sz - 1)];
                    e.tm = twin.tm;
                    e.ch = twin.ch;
                    e.num = twin.num;
                end
                do_insert(e);
            end
            else if (pick < 75)
            begin
                if (sz > 0 && $urandom_range(9) < 8)
                begin
                    e = live_entries[$urandom_range(sz - 1)];
                    // near miss: one attribute or the num field off by a bit
                    if ($urandom_range(4) == 0)
                    begin
                        case ($urandom_range(3))
                            0:       e.aux[$urandom_range(15)] ^= 1'b1;
                            1:       e.st[$urandom_range(7)] ^= 1'b1;
                            2:       e.ty[$urandom_range(7)] ^= 1'b1;
                            default: e.num[$urandom_range(7)] ^= 1'b1;
                        endcase
                    end
                end
                else
                begin
                    e = random_entry();
                end
                do_delete(e);
            end
            else if (pick < 97)
            begin
                if (sz > 0 && $urandom_range(3) != 0)
                    issue_op(ACT_READ, random_entry(), INDEX_IN_W'($urandom_range(sz - 1)));
                else
                    issue_op(ACT_READ, random_entry(), INDEX_IN_W'($urandom_range(63)));
            end
            else
            begin
                issue_op(ACT_UNUSED, random_entry(), INDEX_IN_W'($urandom_range(63)));
            end
        end
    endtask

    // main stimulus and verdict
    initial
    begin
        ann_entry_t zero_e;
        ann_entry_t zero2_e;
        ann_entry_t max_e;
        ann_entry_t twin_e;
        ann_entry_t mid_e;
        ann_entry_t miss_e;

        // every input known from time zero, reset held low
        rst_n = 1'b0;
        in_valid = 1'b0;
        action = ACT_INSERT;
        event_time = '0;
        channel = '0;
        offset_num = '0;
        ann_type = '0;
        sub_type = '0;
        aux_tag = '0;
        read_index = '0;
        foreach (ops_sent[i])
            ops_sent[i] = 0;
        filling = 1'b1;

        // first phase: sender idles less than the receiver
        send_idle_pct = 32;
        recv_idle_pct = 74;

        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        zero_e = '0;
        max_e = '{tm: 32'hFFFF_FFFF, ch: 8'hFF, num: 8'h7F, ty: 8'hFF, st: 8'h7F,
                  aux: 16'hFFFF};
        twin_e = max_e;
        twin_e.st = 8'h80;
        twin_e.aux = 16'h0001;
        mid_e = '{tm: 32'h8000_0000, ch: 8'h55, num: 8'h00, ty: 8'h01, st: 8'hFF,
                  aux: 16'h0000};
        zero2_e = zero_e;
        zero2_e.aux = 16'h0005;

        // empty table: read out of range, delete finds nothing, unused code
        issue_op(ACT_READ, zero_e, '0);
        do_delete(zero_e);
        issue_op(ACT_UNUSED, max_e, '1);
        // key zero goes in like any other, then the largest key and an equal-key twin
        do_insert(zero_e);
        do_insert(max_e);
        do_insert(twin_e);
        do_insert(mid_e);
        // second key zero must land in front of the first
        do_insert(zero2_e);
        // walk the whole table, two indices past the count, and the top index
        for (int i = 0; i < 7; i++)
            issue_op(ACT_READ, max_e, INDEX_IN_W'(i));
        issue_op(ACT_READ, zero_e, '1);
        // right key, wrong aux tag: no match
        miss_e = max_e;
        miss_e.aux = 16'hFFFE;
        do_delete(miss_e);
        // exact matches on the twin of the equal-key pair and on key zero
        do_delete(twin_e);
        do_delete(zero_e);
        for (int i = 0; i < 3; i++)
            issue_op(ACT_READ, zero_e, INDEX_IN_W'(i));
        issue_op(ACT_UNUSED, zero_e, '0);
        // subtype off by sign only
        miss_e = mid_e;
        miss_e.st = 8'h7F;
        do_delete(miss_e);

        // random part, with one long receiver hold-off mid phase
        random_ops(150);
        hold_trig++;
        random_ops(310);

        // second phase: sender idles more than the receiver
        send_idle_pct = 74;
        recv_idle_pct = 32;
        random_ops(460);

        // last phase: no idling at all, another long hold-off while beats keep coming
        send_idle_pct = 0;
        recv_idle_pct = 0;
        random_ops(100);
        hold_trig++;
        random_ops(360);

        in_valid <= 1'b0;

        // all replies in, then leave room for anything stray
        wait (pending == 0);
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("covered %0d beats: %0d inserts, %0d deletes, %0d reads, %0d unused codes",
                 ops_sent[ACT_INSERT] + ops_sent[ACT_DELETE] + ops_sent[ACT_READ]
                 + ops_sent[ACT_UNUSED], ops_sent[ACT_INSERT], ops_sent[ACT_DELETE],
                 ops_sent[ACT_READ], ops_sent[ACT_UNUSED]);
        $display("%0d replies checked, fill peaked at %0d, %0d full rejects, %0d missed deletes",
                 replies_checked, peak_fill, full_rejects, unmatched_deletes);
        if (fail_count == 0 && pending == 0)
            $display("sorted_annotation_table_core verification clean");
        else
            $display("sorted_annotation_table_core verification failed");
        $finish;
    end

    // watchdog: the slowest legal run is roughly 1400 beats, each at worst a delete
    // scan plus compaction, plus stalls, and it ends before this limit
    initial
    begin
        #2_000_000;
        $display("sorted_annotation_table_core verification failed");
        $finish;
    end

endmodule

@@ filelist.f @@
hdl/sat_pkg.sv
hdl/sat_ram.sv
hdl/sat_datapath.sv
hdl/sat_ctrl.sv
hdl/sorted_annotation_table_core.sv
hdl/sat_checker.sv
tb/sat_table_checker.sv
tb/tb_sorted_annotation_table_core.sv
